>>> rtl/core/polyline_linear_upsampler_unit_defines.svh
// assertion macros for the polyline linear upsampler
// used by the top level and plu_div, no other dependencies
`ifndef POLYLINE_LINEAR_UPSAMPLER_UNIT_DEFINES_SVH
`define POLYLINE_LINEAR_UPSAMPLER_UNIT_DEFINES_SVH

`ifndef SYNTH

`define PLU_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PLU_ASSERT(lbl, prop, msg) \
    `PLU_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`else

`define PLU_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define PLU_ASSERT(lbl, prop, msg)

`endif

`endif

>>> rtl/core/plu_pkg.sv
// shared types and constants for the polyline linear upsampler
// no dependencies
package plu_pkg;

    localparam int C_COORD_W   = 32;
    localparam int C_K_W       = 6;
    localparam int C_DIV_W     = C_COORD_W + 1;
    localparam int C_DIV_CNT_W = $clog2(C_DIV_W + 1);

    typedef struct packed {
        logic signed [C_COORD_W-1:0] px;
        logic signed [C_COORD_W-1:0] py;
        logic                        end_of_path;
    } t_in_item;

    typedef struct packed {
        logic signed [C_COORD_W-1:0] qx;
        logic signed [C_COORD_W-1:0] qy;
        logic                        interpolated;
        logic                        run_last;
    } t_out_item;

    typedef struct packed {
        logic                      done;
        logic signed [C_DIV_W-1:0] quot;
        logic [C_K_W-1:0]          rem;
    } t_div_res;

endpackage

>>> rtl/core/polyline_linear_upsampler_unit.sv
// top level of the polyline linear upsampler: sequencer, step accumulators, output register
// depends on plu_pkg, plu_div and the assertion macro header
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we, no wait          | i_cfg_data (points_between)
//
// first point of a path: taken with no result, or one result if it carries the end flag
// otherwise two serial divisions on the shared divider (x then y),
// then k+1 results (k+2 with end flag) at one a cycle while the output is not stalled
// a stalled output register holds the sequencer; input is not ready until the item is done
// synchronous active-low reset; no clearing pass
`include "polyline_linear_upsampler_unit_defines.svh"

module polyline_linear_upsampler_unit #(
    parameter int MAX_BETWEEN = 62
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  plu_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output plu_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_we,
    input  logic [plu_pkg::C_K_W-1:0] i_cfg_data
);
    import plu_pkg::*;

    localparam int J_W = (MAX_BETWEEN < 2) ? 1 : $clog2(MAX_BETWEEN + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIVX = 3'd1;
    localparam logic [2:0] S_DIVY = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_TAIL = 3'd4;

    logic [2:0]                 r_state;
    logic                       r_have_prev;
    logic                       r_ov;
    logic [C_K_W-1:0]           r_cfg;
    t_out_item                  r_out;
    logic signed [C_COORD_W-1:0] r_prev_x, r_prev_y, r_cur_x, r_cur_y;
    logic                       r_last;
    logic [J_W-1:0]             r_k, r_j;
    logic [C_K_W-1:0]           r_div;
    logic signed [C_DIV_W-1:0]  r_qdx, r_qdy, r_qx, r_qy;
    logic [C_K_W-1:0]           r_rdx, r_rdy, r_rx, r_ry;

    logic                       w_acc;
    logic                       w_load;
    logic [J_W-1:0]             w_ksat;
    logic signed [C_DIV_W-1:0]  w_dx_in, w_dy, w_div_num;
    logic                       w_div_start;
    t_div_res                   w_div;
    logic [C_K_W:0]             w_rsx, w_rsy;
    logic                       w_wrapx, w_wrapy;
    logic                       w_jend;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_load      = !r_ov || i_out_ready;
    assign w_jend      = (r_j == r_k);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    assign w_ksat = (r_cfg > C_K_W'(MAX_BETWEEN)) ? J_W'(MAX_BETWEEN) : J_W'(r_cfg);

    // deltas carry one extra bit so no segment overflows
    assign w_dx_in = {i_in_data.px[C_COORD_W-1], i_in_data.px}
                   - {r_prev_x[C_COORD_W-1], r_prev_x};
    assign w_dy    = {r_cur_y[C_COORD_W-1], r_cur_y} - {r_prev_y[C_COORD_W-1], r_prev_y};

    assign w_div_start = (w_acc && r_have_prev) || ((r_state == S_DIVX) && w_div.done);
    assign w_div_num   = (r_state == S_IDLE) ? w_dx_in : w_dy;

    plu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   ((r_state == S_IDLE) ? (C_K_W'(w_ksat) + C_K_W'(1)) : r_div),
        .o_res   (w_div)
    );

    // running floor(delta*j/(k+1)) kept as quotient and remainder
    assign w_rsx   = {1'b0, r_rx} + {1'b0, r_rdx};
    assign w_rsy   = {1'b0, r_ry} + {1'b0, r_rdy};
    assign w_wrapx = w_rsx >= {1'b0, r_div};
    assign w_wrapy = w_rsy >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_ov        <= 1'b0;
            r_cfg       <= C_K_W'(1);
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (r_have_prev) begin
                            r_state <= S_DIVX;
                        end else if (i_in_data.end_of_path) begin
                            r_state <= S_TAIL;
                        end else begin
                            r_have_prev <= 1'b1;
                        end
                    end
                end
                S_DIVX: begin
                    if (w_div.done) begin
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (w_div.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_ov <= 1'b1;
                        if (w_jend) begin
                            if (r_last) begin
                                r_state <= S_TAIL;
                            end else begin
                                r_state     <= S_IDLE;
                                r_have_prev <= 1'b1;
                            end
                        end
                    end
                end
                S_TAIL: begin
                    if (w_load) begin
                        r_ov        <= 1'b1;
                        r_state     <= S_IDLE;
                        r_have_prev <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    r_cur_x <= i_in_data.px;
                    r_cur_y <= i_in_data.py;
                    r_last  <= i_in_data.end_of_path;
                    r_k     <= w_ksat;
                    r_div   <= C_K_W'(w_ksat) + C_K_W'(1);
                    if (!r_have_prev) begin
                        r_prev_x <= i_in_data.px;
                        r_prev_y <= i_in_data.py;
                    end
                end
            end
            S_DIVX: begin
                if (w_div.done) begin
                    r_qdx <= w_div.quot;
                    r_rdx <= w_div.rem;
                end
            end
            S_DIVY: begin
                if (w_div.done) begin
                    r_qdy <= w_div.quot;
                    r_rdy <= w_div.rem;
                    r_qx  <= '0;
                    r_qy  <= '0;
                    r_rx  <= '0;
                    r_ry  <= '0;
                    r_j   <= '0;
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    r_out.qx           <= r_prev_x + r_qx[C_COORD_W-1:0];
                    r_out.qy           <= r_prev_y + r_qy[C_COORD_W-1:0];
                    r_out.interpolated <= (r_j != '0);
                    r_out.run_last     <= w_jend && !r_last;
                    r_qx <= r_qx + r_qdx + C_DIV_W'(w_wrapx);
                    r_qy <= r_qy + r_qdy + C_DIV_W'(w_wrapy);
                    r_rx <= w_wrapx ? (w_rsx[C_K_W-1:0] - r_div) : w_rsx[C_K_W-1:0];
                    r_ry <= w_wrapy ? (w_rsy[C_K_W-1:0] - r_div) : w_rsy[C_K_W-1:0];
                    r_j  <= r_j + J_W'(1);
                    if (w_jend && !r_last) begin
                        r_prev_x <= r_cur_x;
                        r_prev_y <= r_cur_y;
                    end
                end
            end
            S_TAIL: begin
                if (w_load) begin
                    r_out.qx           <= r_cur_x;
                    r_out.qy           <= r_cur_y;
                    r_out.interpolated <= 1'b0;
                    r_out.run_last     <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    `PLU_ASSERT(a_rem_below_div, (r_state == S_EMIT) |-> (r_rx < r_div && r_ry < r_div), "step remainder out of range")
    `PLU_ASSERT(a_j_bound, (r_state == S_EMIT) |-> (r_j <= r_k), "step index past k")
    `PLU_ASSERT(a_div_done_state, w_div.done |-> (r_state == S_DIVX || r_state == S_DIVY), "divider result with no division pending")
    `PLU_ASSERT(a_seg_starts_div, (w_acc && r_have_prev) |=> (r_state == S_DIVX), "segment did not start division")

endmodule

>>> rtl/core/plu_div.sv
// bit-serial floor divider: signed segment delta by small unsigned divisor
// depends on plu_pkg and the assertion macro header
`include "polyline_linear_upsampler_unit_defines.svh"

module plu_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [plu_pkg::C_DIV_W-1:0]  i_num,
    input  logic [plu_pkg::C_K_W-1:0]           i_den,
    output plu_pkg::t_div_res                   o_res
);
    import plu_pkg::*;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIX  = 2'd2;

    logic [1:0]             r_phase;
    logic                   r_done;
    logic                   r_neg;
    logic [C_DIV_CNT_W-1:0] r_cnt;
    logic [C_DIV_W-1:0]     r_num;
    logic [C_K_W-1:0]       r_rem;
    logic [C_K_W-1:0]       r_d;

    logic [C_K_W:0]   w_sh;
    logic [C_K_W:0]   w_sub;
    logic             w_ge;
    logic [C_DIV_W-1:0] w_mag;

    assign w_sh  = {r_rem, r_num[C_DIV_W-1]};
    assign w_ge  = w_sh >= {1'b0, r_d};
    assign w_sub = w_sh - {1'b0, r_d};
    assign w_mag = i_num[C_DIV_W-1] ? (C_DIV_W'(0) - i_num) : i_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                D_IDLE: begin
                    if (i_start) begin
                        r_phase <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (r_cnt == C_DIV_CNT_W'(1)) begin
                        r_phase <= D_FIX;
                    end
                end
                D_FIX: begin
                    r_phase <= D_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_phase <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            D_IDLE: begin
                if (i_start) begin
                    r_num <= w_mag;
                    r_neg <= i_num[C_DIV_W-1];
                    r_rem <= '0;
                    r_d   <= i_den;
                    r_cnt <= C_DIV_CNT_W'(C_DIV_W);
                end
            end
            D_RUN: begin
                // one quotient bit a cycle, msb first
                r_rem <= w_ge ? w_sub[C_K_W-1:0] : w_sh[C_K_W-1:0];
                r_num <= {r_num[C_DIV_W-2:0], w_ge};
                r_cnt <= r_cnt - C_DIV_CNT_W'(1);
            end
            D_FIX: begin
                // turn the magnitude result into floor division
                if (r_neg) begin
                    if (r_rem != '0) begin
                        r_num <= ~r_num;
                        r_rem <= r_d - r_rem;
                    end else begin
                        r_num <= C_DIV_W'(0) - r_num;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_num;
    assign o_res.rem  = r_rem;

    `PLU_ASSERT(a_start_idle, i_start |-> (r_phase == D_IDLE), "divider started while busy")
    `PLU_ASSERT(a_rem_bound, (r_phase == D_RUN) |-> (r_rem < r_d), "remainder not below divisor")
    `PLU_ASSERT(a_done_pulse, r_done |=> !r_done, "done held for more than one cycle")

endmodule

>>> tb/tb.sv
// self-checking testbench for polyline_linear_upsampler_unit: path points in, upsampled points out
// predicts every emitted point in a small scoreboard class; depends on plu_pkg and the rtl only
`timescale 1ns / 1ps

module tb;
    import plu_pkg::*;

    localparam int C_MAX_BETWEEN = 62;
    localparam int C_IDLE_WAIT   = 160;
    localparam int C_STALL_LIMIT = 2000;
    localparam int C_HOLD_CYCLES = 400;
    localparam int C_REPORT_MAX  = 10;

    class upsample_scoreboard;
        logic [C_K_W-1:0] points_between;
        longint           prev_x;
        longint           prev_y;
        bit               have_prev;
        t_out_item        expected_points[$];
        int               failures;

        function new();
            points_between = 6'd1;
            prev_x         = 0;
            prev_y         = 0;
            have_prev      = 1'b0;
            failures       = 0;
        endfunction

        function void set_points_between(input logic [C_K_W-1:0] value);
            points_between = value;
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        function longint floor_div(input longint num, input longint den);
            longint q;
            q = num / den;
            if ((num % den) != 0 && num < 0) q = q - 1;
            return q;
        endfunction

        function void push_point(input longint x, input longint y, input bit interp);
            t_out_item r;
            r.qx           = x[C_COORD_W-1:0];
            r.qy           = y[C_COORD_W-1:0];
            r.interpolated = interp;
            r.run_last     = 1'b0;
            expected_points.insert(expected_points.size(), r);
        endfunction

        // on accept: held previous point and inserted ones, then the end point if flagged
        function void note_point(input t_in_item p);
            longint cx;
            longint cy;
            longint dx;
            longint dy;
            longint kk;
            longint j;
            int     first_new;
            cx = $signed(p.px);
            cy = $signed(p.py);
            first_new = expected_points.size();
            if (have_prev) begin
                kk = (points_between > C_MAX_BETWEEN) ? C_MAX_BETWEEN : points_between;
                dx = cx - prev_x;
                dy = cy - prev_y;
                push_point(prev_x, prev_y, 1'b0);
                for (j = 1; j <= kk; j++) begin
                    push_point(prev_x + floor_div(dx * j, kk + 1),
                               prev_y + floor_div(dy * j, kk + 1), 1'b1);
                end
            end
            if (p.end_of_path) push_point(cx, cy, 1'b0);
            if (expected_points.size() > first_new)
                expected_points[expected_points.size() - 1].run_last = 1'b1;
            prev_x    = cx;
            prev_y    = cy;
            have_prev = !p.end_of_path;
        endfunction

        function void check_point(input t_out_item got);
            t_out_item want;
            if (expected_points.size() == 0) begin
                failures++;
                if (failures <= C_REPORT_MAX)
                    $display("unexpected point qx=%h qy=%h interp=%b last=%b",
                             got.qx, got.qy, got.interpolated, got.run_last);
                return;
            end
            want = expected_points.pop_front();
            if (got.qx !== want.qx || got.qy !== want.qy ||
                got.interpolated !== want.interpolated || got.run_last !== want.run_last) begin
                failures++;
                if (failures <= C_REPORT_MAX)
                    $display("mismatch: exp %h %h %b %b, got %h %h %b %b",
                             want.qx, want.qy, want.interpolated, want.run_last,
                             got.qx, got.qy, got.interpolated, got.run_last);
            end
        endfunction
    endclass

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             in_valid   = 1'b0;
    t_in_item         in_data    = '0;
    logic             out_ready  = 1'b0;
    logic             cfg_we     = 1'b0;
    logic [C_K_W-1:0] cfg_data   = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    t_out_item        o_out_data;

    upsample_scoreboard sb;
    bit               hold_req   = 1'b0;
    bit               calm       = 1'b0;
    bit               run_active = 1'b0;
    int               idle_cycles = 0;
    int               items_sent  = 0;

    polyline_linear_upsampler_unit #(
        .MAX_BETWEEN (C_MAX_BETWEEN)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) sb.note_point(in_data);
            if (o_out_valid && out_ready) sb.check_point(o_out_data);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || !run_active)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= C_STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (C_HOLD_CYCLES) @(posedge i_clk);
            end
            if (calm) out_ready <= 1'b1;
            else      out_ready <= ($urandom_range(99) >= 16);
        end
    end

    task automatic send_point(input t_in_item p);
        if (!calm && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_xy(input logic [31:0] x, input logic [31:0] y, input bit eop);
        t_in_item p;
        p.px          = x;
        p.py          = y;
        p.end_of_path = eop;
        send_point(p);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // only while idle: drain, let the sequencer settle, then write
    task automatic write_points_between(input logic [C_K_W-1:0] value);
        in_valid <= 1'b0;
        wait_drained();
        repeat (C_IDLE_WAIT) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        sb.set_points_between(value);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coord(input logic [31:0] near);
        logic [31:0] c;
        case ($urandom_range(3))
            0: c = $urandom;
            1: c = 32'($urandom_range(2000)) - 32'd1000;
            2: c = near + 32'($urandom_range(512)) - 32'd256;
            default: begin
                case ($urandom_range(3))
                    0: c = 32'h7FFF_FFFF;
                    1: c = 32'h8000_0000;
                    2: c = '0;
                    default: c = '1;
                endcase
            end
        endcase
        return c;
    endfunction

    // mostly well-formed paths; a few broken ones with stray or missing end flags
    task automatic send_path(input int len);
        t_in_item p;
        bit       broken;
        int       i;
        p = '0;
        broken = ($urandom_range(9) == 0);
        for (i = 0; i < len; i++) begin
            if (i == 0 || $urandom_range(9) != 0) begin
                p.px = pick_coord(p.px);
                p.py = pick_coord(p.py);
            end
            if (broken) p.end_of_path = $urandom_range(1);
            else        p.end_of_path = (i == len - 1);
            send_point(p);
        end
    endtask

    initial begin
        logic [C_K_W-1:0] k_plan[6];
        int               ph;
        int               target;
        k_plan[0] = 6'd62;
        k_plan[1] = 6'd0;
        k_plan[2] = 6'($urandom_range(61, 1));
        k_plan[3] = 6'd63;
        k_plan[4] = 6'($urandom_range(61, 1));
        k_plan[5] = 6'd2;
        sb = new();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_active = 1'b1;

        // reset value of k (one inserted point)
        send_xy(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);   // lone point that also ends the path
        send_xy(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_xy(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);   // full span on both axes
        send_xy(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);   // zero-length segment
        send_xy(-32'sd5, 32'sd7, 1'b0);
        send_xy(-32'sd4, 32'sd8, 1'b1);
        send_xy(32'd0, 32'd0, 1'b0);                   // new path after end
        send_xy(-32'sd1, -32'sd1, 1'b1);               // negative odd delta rounds down

        write_points_between(6'd0);
        send_xy(32'd1, 32'd2, 1'b0);
        send_xy(32'h7FFF_FFFF, 32'd0, 1'b0);
        send_xy(32'd3, -32'sd3, 1'b1);

        write_points_between(6'd63);                   // saturates to the maximum
        send_xy(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_xy(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_xy(32'd100, -32'sd100, 1'b0);
        send_xy(-32'sd100, 32'sd100, 1'b1);

        for (ph = 0; ph < 6; ph++) begin
            write_points_between(k_plan[ph]);
            if (ph == 4) calm = 1'b1;
            target = items_sent + 15;
            if (ph == 1) hold_req = 1'b1;
            while (items_sent < target) begin
                if (ph == 2 && items_sent >= target - 10 && items_sent < target - 6) begin
                    in_valid <= 1'b0;
                    wait_drained();
                    @(posedge i_clk);
                end
                send_path($urandom_range(8, 1));
            end
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (C_IDLE_WAIT) @(posedge i_clk);
        run_active = 1'b0;
        if (sb.pending() != 0) begin
            sb.failures++;
            $display("%0d expected points never arrived", sb.pending());
        end
        if (sb.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/plu_pkg.sv
rtl/core/plu_div.sv
rtl/core/polyline_linear_upsampler_unit.sv
tb/tb.sv
